FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the decoder's queue and back modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of aclk, ignored while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check on every rising edge of aclk, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

FILE: design/sbusd_pkg.sv
// ---------------------------------------------------------------------------
// sbusd_pkg
// Types, constants and decode functions of the SBUS frame decoder.
// ---------------------------------------------------------------------------
package sbusd_pkg;

    localparam int FRAME_LEN_DEF   = 25;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int NUM_PAYLOAD  = 11;
    localparam int BYTE_CNT_W   = 5;
    localparam int CHAN_W       = 11;
    localparam int LIMIT_W      = 10;
    localparam int POS_W        = 2;

    localparam logic [BYTE_CNT_W-1:0] BYTE_CNT_MAX = 5'd31;
    localparam logic [LIMIT_W-1:0]    STICK_LIMIT_RST = 10'd675;

    localparam logic [CHAN_W-1:0] CODE_HIGH = 11'd1024;
    localparam logic [CHAN_W-1:0] CODE_MID  = 11'd1694;
    localparam logic [CHAN_W-1:0] CODE_LOW  = 11'd353;

    localparam logic [POS_W-1:0] POS_NONE = 2'd0;
    localparam logic [POS_W-1:0] POS_LOW  = 2'd1;
    localparam logic [POS_W-1:0] POS_MID  = 2'd2;
    localparam logic [POS_W-1:0] POS_HIGH = 2'd3;

    // Bytes 1..11 of a frame, byte 1 in the low bits.
    typedef struct packed {
        logic [NUM_PAYLOAD*8-1:0] payload;
        logic                     good;
    } frame_rec_t;

    // Centre a raw stick code and zero it when out of limit.
    function automatic logic signed [CHAN_W-1:0] stick_value(
        input logic [CHAN_W-1:0]  raw,
        input logic [LIMIT_W-1:0] limit
    );
        logic [CHAN_W-1:0] centred;
        logic [CHAN_W-1:0] mag;
        centred = {~raw[CHAN_W-1], raw[CHAN_W-2:0]};
        mag     = centred[CHAN_W-1] ? (~centred + 11'd1) : centred;
        return (mag > {1'b0, limit}) ? '0 : $signed(centred);
    endfunction

    // Map a switch code; an unknown code keeps the previous position.
    function automatic logic [POS_W-1:0] switch_map(
        input logic [CHAN_W-1:0] code,
        input logic [POS_W-1:0]  prev,
        input logic              three_pos,
        input logic              has_high,
        input logic              has_mid
    );
        logic [POS_W-1:0] pos;
        pos = prev;
        if (has_high && code == CODE_HIGH) begin
            pos = three_pos ? POS_HIGH : POS_MID;
        end else if (has_mid && code == CODE_MID) begin
            pos = POS_MID;
        end else if (code == CODE_LOW) begin
            pos = POS_LOW;
        end
        return pos;
    endfunction

endpackage

FILE: design/sbusd_front.sv
// ---------------------------------------------------------------------------
// sbusd_front
// Counts the words of a frame, keeps bytes 1 to 11 and queues a frame
// record with its length check on the word that ends the frame.
// ---------------------------------------------------------------------------
module sbusd_front #(
    parameter int FRAME_LEN = sbusd_pkg::FRAME_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    input  logic                  s_frame_end,
    input  logic                  q_full,
    output logic                  q_push,
    output sbusd_pkg::frame_rec_t q_rec
);

    logic [sbusd_pkg::BYTE_CNT_W-1:0] byte_count_reg, byte_count_next;
    logic [sbusd_pkg::BYTE_CNT_W-1:0] total;
    logic [7:0] payload_reg [sbusd_pkg::NUM_PAYLOAD];
    logic [7:0] payload_next [sbusd_pkg::NUM_PAYLOAD];
    logic       accept;
    logic [3:0] wr_idx;
    logic       wr_en;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign wr_idx  = 4'(byte_count_reg - 5'd1);
    assign wr_en   = accept && byte_count_reg >= 5'd1
                     && byte_count_reg <= 5'(sbusd_pkg::NUM_PAYLOAD);
    assign total   = (byte_count_reg < sbusd_pkg::BYTE_CNT_MAX) ?
                     byte_count_reg + 5'd1 : sbusd_pkg::BYTE_CNT_MAX;

    always_comb begin
        for (int i = 0; i < sbusd_pkg::NUM_PAYLOAD; i++) begin
            payload_next[i] = (wr_en && wr_idx == 4'(i)) ? s_data_byte : payload_reg[i];
        end
        byte_count_next = byte_count_reg;
        if (accept) begin
            byte_count_next = s_frame_end ? '0 : total;
        end
    end

    // The record takes this word's byte too: a short frame may end on byte 11.
    always_comb begin
        for (int i = 0; i < sbusd_pkg::NUM_PAYLOAD; i++) begin
            q_rec.payload[i*8 +: 8] = payload_next[i];
        end
        q_rec.good = (total == 5'(FRAME_LEN));
    end

    assign q_push = accept && s_frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < sbusd_pkg::NUM_PAYLOAD; i++) begin
            payload_reg[i] <= payload_next[i];
        end
    end

endmodule

FILE: design/sbusd_fifo.sv
// ---------------------------------------------------------------------------
// sbusd_fifo
// Short first-in first-out queue of frame records between front and back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbusd_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = sbusd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data,
    input  logic             pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_CLK(a_fifo_count_bound, count_reg <= CNT_FULL, "queue count exceeds depth")
    `ASSERT_CLK(a_fifo_no_overflow, push |-> !full, "frame record pushed into full queue")
    `ASSERT_CLK(a_fifo_count_up, (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1,
                "queue count did not advance on push")

endmodule

FILE: design/sbusd_back.sv
// ---------------------------------------------------------------------------
// sbusd_back
// Unpacks a queued frame record into sticks and switch positions and
// holds the result in the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sbusd_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  sbusd_pkg::frame_rec_t                q_rec,
    output logic                                 q_pop,
    input  logic [sbusd_pkg::LIMIT_W-1:0]        stick_limit,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sbusd_pkg::CHAN_W-1:0]  m_left_x,
    output logic signed [sbusd_pkg::CHAN_W-1:0]  m_left_y,
    output logic signed [sbusd_pkg::CHAN_W-1:0]  m_right_x,
    output logic signed [sbusd_pkg::CHAN_W-1:0]  m_right_y,
    output logic [sbusd_pkg::POS_W-1:0]          m_switch_a_pos,
    output logic [sbusd_pkg::POS_W-1:0]          m_switch_b_pos,
    output logic [sbusd_pkg::POS_W-1:0]          m_switch_c_pos,
    output logic [sbusd_pkg::POS_W-1:0]          m_switch_d_pos,
    output logic                                 m_frame_good
);

    localparam int CW = sbusd_pkg::CHAN_W;
    localparam int PW = sbusd_pkg::POS_W;

    logic [PW-1:0] sw_pos_reg [4];
    logic [PW-1:0] sw_pos_next [4];
    logic [PW-1:0] sw_map [4];
    logic [CW-1:0] sw_code [4];
    logic [CW-1:0] raw_rx, raw_ry, raw_ly, raw_lx;

    logic                 m_valid_reg, m_valid_next;
    logic signed [CW-1:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic signed [CW-1:0] lx_next, ly_next, rx_next, ry_next;
    logic                 good_reg;

    // Eleven-bit channels packed least significant bit first from byte 1.
    assign raw_rx     = q_rec.payload[0*CW +: CW];
    assign raw_ry     = q_rec.payload[1*CW +: CW];
    assign raw_ly     = q_rec.payload[2*CW +: CW];
    assign raw_lx     = q_rec.payload[3*CW +: CW];
    assign sw_code[0] = q_rec.payload[4*CW +: CW];
    assign sw_code[1] = q_rec.payload[5*CW +: CW];
    assign sw_code[2] = q_rec.payload[6*CW +: CW];
    assign sw_code[3] = q_rec.payload[7*CW +: CW];

    assign q_pop = q_valid && (!m_valid_reg || m_ready);

    always_comb begin
        sw_map[0] = sbusd_pkg::switch_map(sw_code[0], sw_pos_reg[0], 1'b0, 1'b1, 1'b0);
        sw_map[1] = sbusd_pkg::switch_map(sw_code[1], sw_pos_reg[1], 1'b1, 1'b1, 1'b1);
        sw_map[2] = sbusd_pkg::switch_map(sw_code[2], sw_pos_reg[2], 1'b1, 1'b1, 1'b1);
        sw_map[3] = sbusd_pkg::switch_map(sw_code[3], sw_pos_reg[3], 1'b0, 1'b0, 1'b1);
        for (int i = 0; i < 4; i++) begin
            sw_pos_next[i] = sw_pos_reg[i];
            if (q_pop) begin
                // a bad frame drops every switch back to none
                sw_pos_next[i] = q_rec.good ? sw_map[i] : sbusd_pkg::POS_NONE;
            end
        end
        if (q_rec.good) begin
            lx_next = sbusd_pkg::stick_value(raw_lx, stick_limit);
            ly_next = sbusd_pkg::stick_value(raw_ly, stick_limit);
            rx_next = sbusd_pkg::stick_value(raw_rx, stick_limit);
            ry_next = sbusd_pkg::stick_value(raw_ry, stick_limit);
        end else begin
            lx_next = '0;
            ly_next = '0;
            rx_next = '0;
            ry_next = '0;
        end
        m_valid_next = m_valid_reg;
        if (q_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                sw_pos_reg[i] <= sbusd_pkg::POS_NONE;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < 4; i++) begin
                sw_pos_reg[i] <= sw_pos_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            lx_reg   <= lx_next;
            ly_reg   <= ly_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            good_reg <= q_rec.good;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_x       = lx_reg;
    assign m_left_y       = ly_reg;
    assign m_right_x      = rx_reg;
    assign m_right_y      = ry_reg;
    assign m_switch_a_pos = sw_pos_reg[0];
    assign m_switch_b_pos = sw_pos_reg[1];
    assign m_switch_c_pos = sw_pos_reg[2];
    assign m_switch_d_pos = sw_pos_reg[3];
    assign m_frame_good   = good_reg;

    `ASSERT_CLK(a_back_bad_zero, (m_valid_reg && !good_reg) |-> (lx_reg == '0 && ly_reg == '0
                && rx_reg == '0 && ry_reg == '0 && sw_pos_reg[0] == '0 && sw_pos_reg[1] == '0
                && sw_pos_reg[2] == '0 && sw_pos_reg[3] == '0), "bad frame result not cleared")
    `ASSERT_CLK(a_back_two_pos, sw_pos_reg[0] != sbusd_pkg::POS_HIGH
                && sw_pos_reg[3] != sbusd_pkg::POS_HIGH, "two-position switch at third position")
    `ASSERT_CLK(a_back_pop_valid, q_pop |=> m_valid_reg, "popped record did not reach output")

endmodule

FILE: design/sbus_frame_channel_decoder_unit.sv
// ---------------------------------------------------------------------------
// sbus_frame_channel_decoder_unit
// Decodes received SBUS words into four centred sticks and four switches.
// ---------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_data_byte, s_frame_end
//  m_        out        m_valid / m_ready    sticks, switch positions, m_frame_good
//  cfg_      in         cfg_valid/cfg_ready  cfg_data (stick limit)
//
//  One word is taken every cycle while the queue is not full; a frame-end word
//  is queued as a record and moves into the output register once it is free.
//  A queue of QUEUE_DEPTH frame records parts the byte counter from the
//  decode stage, so s_ready only drops once that queue is full.
//  Reset (aresetn low, synchronous) clears byte count, queue, switches and
//  output valid, and loads the stick limit with 675; no clearing pass.
// ---------------------------------------------------------------------------
module sbus_frame_channel_decoder_unit #(
    parameter int FRAME_LEN   = sbusd_pkg::FRAME_LEN_DEF,
    parameter int QUEUE_DEPTH = sbusd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [7:0]                           s_data_byte,
    input  logic                                 s_frame_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sbusd_pkg::CHAN_W-1:0]  m_left_x,
    output logic signed [sbusd_pkg::CHAN_W-1:0]  m_left_y,
    output logic signed [sbusd_pkg::CHAN_W-1:0]  m_right_x,
    output logic signed [sbusd_pkg::CHAN_W-1:0]  m_right_y,
    output logic [sbusd_pkg::POS_W-1:0]          m_switch_a_pos,
    output logic [sbusd_pkg::POS_W-1:0]          m_switch_b_pos,
    output logic [sbusd_pkg::POS_W-1:0]          m_switch_c_pos,
    output logic [sbusd_pkg::POS_W-1:0]          m_switch_d_pos,
    output logic                                 m_frame_good,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sbusd_pkg::LIMIT_W-1:0]        cfg_data
);

    localparam int REC_W = $bits(sbusd_pkg::frame_rec_t);

    logic [sbusd_pkg::LIMIT_W-1:0] stick_limit_reg, stick_limit_next;
    logic                  q_full, q_push, q_valid, q_pop;
    sbusd_pkg::frame_rec_t q_wr_rec, q_rd_rec;

    assign cfg_ready = 1'b1;

    always_comb begin
        stick_limit_next = stick_limit_reg;
        if (cfg_valid && cfg_ready) begin
            stick_limit_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_limit_reg <= sbusd_pkg::STICK_LIMIT_RST;
        end else begin
            stick_limit_reg <= stick_limit_next;
        end
    end

    sbusd_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (q_wr_rec)
    );

    sbusd_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_data  (q_wr_rec),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_data  (q_rd_rec),
        .pop      (q_pop)
    );

    sbusd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_rec          (q_rd_rec),
        .q_pop          (q_pop),
        .stick_limit    (stick_limit_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_x       (m_left_x),
        .m_left_y       (m_left_y),
        .m_right_x      (m_right_x),
        .m_right_y      (m_right_y),
        .m_switch_a_pos (m_switch_a_pos),
        .m_switch_b_pos (m_switch_b_pos),
        .m_switch_c_pos (m_switch_c_pos),
        .m_switch_d_pos (m_switch_d_pos),
        .m_frame_good   (m_frame_good)
    );

endmodule
